/* hdl/mlsc_pkg.sv */
// shared types and codes for the moesi line state controller
// no dependencies; used by mlsc_next_state and moesi_line_state_controller_core

package mlsc_pkg;

    localparam int TAG_W = 40;

    // line states
    typedef enum logic [2:0] {
        ST_I = 3'd0,
        ST_M = 3'd1,
        ST_O = 3'd2,
        ST_E = 3'd3,
        ST_S = 3'd4
    } t_state;

    // request kinds
    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_UPDATE = 2'd2,
        OP_EVICT  = 2'd3
    } t_op;

    // events
    typedef enum logic [2:0] {
        CMD_LOCAL_HIT  = 3'd0,
        CMD_LOCAL_MISS = 3'd1,
        CMD_SNOOP_HIT  = 3'd2,
        CMD_SNOOP_MISS = 3'd3,
        CMD_FILL       = 3'd4,
        CMD_COMPLETE   = 3'd5,
        CMD_INVALIDATE = 3'd6,
        CMD_QUERY      = 3'd7
    } t_cmd;

    // coherence actions
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_REPLY = 3'd1,
        ACT_MISS  = 3'd2,
        ACT_CLEAR = 3'd3,
        ACT_SEND  = 3'd4
    } t_act;

    // destinations
    typedef enum logic [1:0] {
        DST_SENDER = 2'd0,
        DST_DIR    = 2'd1,
        DST_LOWER  = 2'd2,
        DST_SOURCE = 2'd3
    } t_dest;

    // configuration register indexes
    localparam logic CFG_LOWEST_PRIVATE = 1'b0;
    localparam logic CFG_PRIVATE_CACHE  = 1'b1;

    // one request; last member sits in the lowest bits
    typedef struct packed {
        logic [2:0]       cmd;
        logic             has_line;
        logic             old_tag_valid;
        logic [TAG_W-1:0] old_tag;
        logic             origin_is_directory;
        logic             message_is_evict;
        logic             message_shared;
        logic             arg_is_self;
        logic             sender_is_lower_link;
        logic [2:0]       supplied_state;
        logic [1:0]       op_type;
        logic [9:0]       line_index;
    } t_req;

    // one result; last member sits in the lowest bits
    typedef struct packed {
        logic             line_valid;
        logic             protocol_error;
        logic [TAG_W-1:0] message_tag;
        logic             response_data;
        logic             shared_flag;
        logic             update_to_upper;
        logic             writeback_lower;
        logic             evict_to_upper;
        logic             evict_to_directory;
        t_dest            dest;
        t_act             action;
        t_state           new_state;
    } t_resp;

endpackage

/* hdl/mlsc_next_state.sv */
// moesi transition logic: old line state and one event in, new state and messages out
// depends on mlsc_pkg

module mlsc_next_state (
    input  mlsc_pkg::t_req  i_req,
    input  logic [2:0]      i_old_state,
    input  logic            i_lowest_private,
    input  logic            i_private_cache,
    output mlsc_pkg::t_resp o_resp
);
    import mlsc_pkg::*;

    always_comb begin
        t_state           old_st;
        t_state           sup;
        t_state           st;
        t_act             act;
        t_dest            dst;
        t_op              op;
        t_cmd             cmd;
        logic             lp;
        logic             ev_dir;
        logic             ev_up;
        logic             wb;
        logic             upd_up;
        logic             shr;
        logic             data;
        logic             perr;
        logic [TAG_W-1:0] tag;

        // decode, with out-of-range states read as invalid
        old_st = (i_old_state <= ST_S) ? t_state'(i_old_state) : ST_I;
        sup    = (i_req.supplied_state <= ST_S) ? t_state'(i_req.supplied_state) : ST_I;
        op     = t_op'(i_req.op_type);
        cmd    = t_cmd'(i_req.cmd);
        lp     = i_lowest_private;
        st     = old_st;
        act    = ACT_NONE;
        dst    = DST_SENDER;
        ev_dir = 1'b0;
        ev_up  = 1'b0;
        wb     = 1'b0;
        upd_up = 1'b0;
        shr    = 1'b0;
        data   = 1'b0;
        perr   = 1'b0;
        tag    = '0;

        case (cmd)
            CMD_LOCAL_HIT: begin
                if (op == OP_EVICT) begin
                    st  = ST_I;
                    act = ACT_CLEAR;
                end else if (op == OP_UPDATE && old_st != ST_M) begin
                    act = ACT_SEND;
                    dst = DST_LOWER;
                end else if (old_st == ST_I) begin
                    act = ACT_MISS;
                end else if (old_st == ST_M || op == OP_READ) begin
                    act = ACT_REPLY;
                end else if (op == OP_WRITE) begin
                    if (lp) begin
                        act = ACT_SEND;
                        dst = DST_DIR;
                    end else begin
                        st  = ST_I;
                        act = ACT_MISS;
                    end
                end
            end
            CMD_LOCAL_MISS: begin
                if (i_req.has_line) st = ST_I;
                act = ACT_SEND;
                dst = (lp && op != OP_UPDATE) ? DST_DIR : DST_LOWER;
            end
            CMD_SNOOP_HIT: begin
                if (op == OP_WRITE) perr = 1'b1;
                if (!lp && op == OP_EVICT) begin
                    st  = ST_I;
                    act = ACT_CLEAR;
                end else if (!lp && op == OP_UPDATE) begin
                    st  = sup;
                    act = ACT_CLEAR;
                end else begin
                    data = 1'b1;
                    act  = ACT_REPLY;
                    dst  = DST_SOURCE;
                    if (old_st == ST_I) begin
                        data   = 1'b0;
                        ev_dir = 1'b1;
                        ev_up  = 1'b1;
                        wb     = 1'b1;
                    end else if (op == OP_READ) begin
                        shr = 1'b1;
                        if (old_st == ST_M || old_st == ST_O) st = ST_O;
                        else if (old_st == ST_E) st = ST_S;
                        if (lp && old_st != ST_S) upd_up = 1'b1;
                    end else if (op == OP_WRITE) begin
                        st = ST_I;
                        if (lp) begin
                            ev_dir = 1'b1;
                            ev_up  = 1'b1;
                            wb     = 1'b1;
                        end
                    end else if (op == OP_EVICT) begin
                        st = ST_I;
                        if (lp) begin
                            ev_up = 1'b1;
                            wb    = 1'b1;
                        end
                    end else begin
                        // update at the lowest private level
                        if (old_st == ST_M || old_st == ST_O) begin
                            if (i_req.sender_is_lower_link) begin
                                st     = i_req.arg_is_self ? ST_O : ST_S;
                                upd_up = 1'b1;
                            end
                        end else begin
                            // clear wins over reply
                            st   = sup;
                            act  = ACT_CLEAR;
                            dst  = DST_SENDER;
                            data = 1'b0;
                        end
                    end
                end
            end
            CMD_SNOOP_MISS: begin
                if (!lp) begin
                    act = ACT_CLEAR;
                end else if (op == OP_EVICT) begin
                    act = ACT_SEND;
                    dst = DST_DIR;
                end else begin
                    ev_dir = 1'b1;
                    ev_up  = 1'b1;
                    wb     = 1'b1;
                    act    = ACT_SEND;
                    dst    = DST_SOURCE;
                end
            end
            CMD_FILL: begin
                if (i_req.old_tag_valid && old_st != ST_I) begin
                    if (lp) begin
                        ev_dir = 1'b1;
                        ev_up  = 1'b1;
                        wb     = 1'b1;
                        tag    = i_req.old_tag;
                    end else if (old_st == ST_M) begin
                        wb  = 1'b1;
                        tag = i_req.old_tag;
                    end
                end
                st = ST_I;
            end
            CMD_COMPLETE: begin
                if (lp) begin
                    if (old_st == ST_I) begin
                        if (i_req.message_shared) begin
                            if (op == OP_READ) st = ST_S;
                            else perr = 1'b1;
                        end else if (op == OP_READ) begin
                            st = ST_E;
                        end else if (op == OP_WRITE) begin
                            st = ST_M;
                        end else if (op == OP_EVICT) begin
                            st = ST_I;
                        end else begin
                            perr = 1'b1;
                        end
                    end else if (old_st == ST_M) begin
                        perr = 1'b1;
                    end else if (op == OP_WRITE) begin
                        st = ST_M;
                    end else begin
                        perr = 1'b1;
                    end
                end else if (i_req.message_is_evict) begin
                    st = ST_I;
                end else if (i_private_cache) begin
                    st = sup;
                end else begin
                    st = ST_E;
                end
            end
            CMD_INVALIDATE: begin
                st = ST_I;
            end
            default: begin
                // query reports the stored state
            end
        endcase

        // reply flags only on a reply, destination only on reply or send
        if (act != ACT_REPLY) begin
            shr  = 1'b0;
            data = 1'b0;
        end
        if (act != ACT_REPLY && act != ACT_SEND) dst = DST_SENDER;

        o_resp.new_state          = st;
        o_resp.action             = act;
        o_resp.dest               = dst;
        o_resp.evict_to_directory = ev_dir;
        o_resp.evict_to_upper     = ev_up;
        o_resp.writeback_lower    = wb;
        o_resp.update_to_upper    = upd_up;
        o_resp.shared_flag        = shr;
        o_resp.response_data      = data;
        o_resp.message_tag        = tag;
        o_resp.protocol_error     = perr;
        o_resp.line_valid         = (st != ST_I);
    end

endmodule

/* hdl/moesi_line_state_controller_core.sv */
// top level of the moesi line state controller: line state memory, pipeline, apb registers
// depends on mlsc_pkg and mlsc_next_state

// The controller keeps a MOESI state for each of LINES cache lines in one synchronous
// memory and takes one event per cycle at full rate while the result stream is not
// stalled. An accepted transaction reads its line and registers its request into
// stage 1, where the transition logic computes the new state and messages, writes the
// state back and loads the result register once that register is free. A write and a
// read of the same line at the same clock edge are bypassed inside the memory, so
// back-to-back events on one line see each other's updates. The line index wraps modulo
// LINES. After reset the memory is swept to invalid, one line per cycle; no transaction
// is accepted during that sweep, while register writes over the APB port are taken at
// any time. Configuration must only change while no transaction is in flight.

module moesi_line_state_controller_core #(
    parameter int LINES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, from bit 0: line_index[9:0], op_type[11:10], supplied_state[14:12],
    // sender_is_lower_link[15], arg_is_self[16], message_shared[17], message_is_evict[18],
    // origin_is_directory[19], old_tag[59:20], old_tag_valid[60], has_line[61], zero[63:62]
    input  logic [63:0] s_axis_tdata,
    // tuser: cmd[2:0]
    input  logic [2:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, from bit 0: new_state[2:0], action[5:3], dest[7:6], evict_to_directory[8],
    // evict_to_upper[9], writeback_lower[10], update_to_upper[11], shared_flag[12],
    // response_data[13], message_tag[53:14], protocol_error[54], line_valid[55]
    output logic [55:0] m_axis_tdata,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mlsc_pkg::*;

    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;

    typedef enum logic [1:0] {
        PH_CLEAR = 2'b01,
        PH_RUN   = 2'b10
    } t_phase;

    // wrap a raw index modulo LINES by conditional subtraction of shifted multiples
    function automatic logic [IDX_W-1:0] wrap_index(input logic [9:0] raw);
        logic [26:0] v;
        logic [26:0] step;
        v = {17'b0, raw};
        for (int k = 9; k >= 0; k--) begin
            step = 27'(LINES) << k;
            if (v >= step) v = v - step;
        end
        return v[IDX_W-1:0];
    endfunction

    t_phase           r_phase;
    logic [IDX_W-1:0] r_clr_idx;
    logic             r_lowest_private;
    logic             r_private_cache;

    logic [2:0]       r_mem [LINES];
    logic [2:0]       r_rd_state;

    logic             r_s1_valid;
    t_req             r_s1_req;
    logic [IDX_W-1:0] r_s1_idx;

    logic             r_out_valid;
    t_resp            r_out;

    t_req             req_in;
    logic [IDX_W-1:0] in_idx;
    logic             in_accept;
    logic             out_free;
    logic             s1_load_out;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [2:0]       mem_wdata;
    t_resp            s1_resp;
    logic             cfg_write;

    // request unpacking and handshake
    assign req_in        = {s_axis_tuser, s_axis_tdata[61:0]};
    assign in_idx        = wrap_index(req_in.line_index);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_load_out   = r_s1_valid && out_free;
    assign s_axis_tready = (r_phase == PH_RUN) && (!r_s1_valid || out_free);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // write port: clearing sweep or write-back of the event in stage 1
    assign mem_we    = (r_phase == PH_CLEAR) || s1_load_out;
    assign mem_waddr = (r_phase == PH_CLEAR) ? r_clr_idx : r_s1_idx;
    assign mem_wdata = (r_phase == PH_CLEAR) ? ST_I : s1_resp.new_state;

    // line state memory with same-edge bypass on the read port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (in_accept) begin
            r_rd_state <= (mem_we && mem_waddr == in_idx) ? mem_wdata : r_mem[in_idx];
        end
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_CLEAR;
            r_clr_idx <= '0;
        end else begin
            case (r_phase)
                PH_CLEAR: begin
                    r_clr_idx <= r_clr_idx + IDX_W'(1);
                    if (r_clr_idx == IDX_W'(LINES - 1)) r_phase <= PH_RUN;
                end
                PH_RUN: begin
                    r_clr_idx <= '0;
                end
                default: begin
                    r_phase <= PH_CLEAR;
                end
            endcase
        end
    end

    // transition logic
    mlsc_next_state u_next_state (
        .i_req            (r_s1_req),
        .i_old_state      (r_rd_state),
        .i_lowest_private (r_lowest_private),
        .i_private_cache  (r_private_cache),
        .o_resp           (s1_resp)
    );

    // stage 1 and result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= in_accept || (r_s1_valid && !s1_load_out);
            r_out_valid <= s1_load_out || (r_out_valid && !m_axis_tready);
        end
    end

    // stage 1 and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_req <= req_in;
            r_s1_idx <= in_idx;
        end
        if (s1_load_out) r_out <= s1_resp;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // configuration registers
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest_private <= 1'b0;
            r_private_cache  <= 1'b0;
        end else if (cfg_write) begin
            case (paddr[2])
                CFG_LOWEST_PRIVATE: r_lowest_private <= pwdata[0];
                CFG_PRIVATE_CACHE:  r_private_cache  <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[2])
            CFG_LOWEST_PRIVATE: prdata = {31'b0, r_lowest_private};
            CFG_PRIVATE_CACHE:  prdata = {31'b0, r_private_cache};
            default:            prdata = '0;
        endcase
    end

endmodule

/* dv/mlsc_coherence_checker.sv */
// checker for the moesi line state controller: watches the request, result and apb channels
// keeps its own copy of the line states and registers, predicts each result, compares in order
// depends on mlsc_pkg
`timescale 1ns / 1ps

module mlsc_coherence_checker #(
    parameter int LINES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_tvalid,
    input  logic        i_req_tready,
    input  logic [63:0] i_req_tdata,
    input  logic [2:0]  i_req_tuser,
    input  logic        i_rsp_tvalid,
    input  logic        i_rsp_tready,
    input  logic [55:0] i_rsp_tdata,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results,
    output int          o_error_results
);
    import mlsc_pkg::*;

    // shadow copy of the line memory and the two mode bits
    t_state shadow_state [LINES];
    logic   lowest_private;
    logic   private_cache;

    // outcomes of accepted requests, oldest first
    t_resp  expected_results [$];

    int     fail_count    = 0;
    int     results_seen  = 0;
    int     error_results = 0;

    // next state and coherence messages of one line for one event
    function automatic t_resp next_line_outcome(input t_req rq, input t_state cur,
                                                input logic lp, input logic pc);
        t_resp            res;
        t_state           st;
        t_state           sup;
        t_act             act;
        t_dest            dst;
        t_op              op;
        logic             ev_dir, ev_up, wb, upd_up, shr, dat, perr;
        logic [TAG_W-1:0] tag;

        op     = t_op'(rq.op_type);
        sup    = (rq.supplied_state <= 3'd4) ? t_state'(rq.supplied_state) : ST_I;
        st     = cur;
        act    = ACT_NONE;
        dst    = DST_SENDER;
        ev_dir = 1'b0;
        ev_up  = 1'b0;
        wb     = 1'b0;
        upd_up = 1'b0;
        shr    = 1'b0;
        dat    = 1'b0;
        perr   = 1'b0;
        tag    = '0;

        case (t_cmd'(rq.cmd))
            CMD_LOCAL_HIT: begin
                if (op == OP_EVICT) begin
                    st  = ST_I;
                    act = ACT_CLEAR;
                end else if (op == OP_UPDATE && cur != ST_M) begin
                    act = ACT_SEND;
                    dst = DST_LOWER;
                end else if (cur == ST_I) begin
                    act = ACT_MISS;
                end else if (cur == ST_M || op == OP_READ) begin
                    act = ACT_REPLY;
                end else if (op == OP_WRITE) begin
                    // write on a valid copy that is not modified: upgrade through the directory or refetch
                    if (lp) begin
                        act = ACT_SEND;
                        dst = DST_DIR;
                    end else begin
                        st  = ST_I;
                        act = ACT_MISS;
                    end
                end
            end
            CMD_LOCAL_MISS: begin
                if (rq.has_line) st = ST_I;
                act = ACT_SEND;
                dst = (lp && op != OP_UPDATE) ? DST_DIR : DST_LOWER;
            end
            CMD_SNOOP_HIT: begin
                perr = (op == OP_WRITE);
                if (!lp && op == OP_EVICT) begin
                    st  = ST_I;
                    act = ACT_CLEAR;
                end else if (!lp && op == OP_UPDATE) begin
                    st  = sup;
                    act = ACT_CLEAR;
                end else begin
                    dat = 1'b1;
                    act = ACT_REPLY;
                    dst = DST_SOURCE;
                    if (cur == ST_I) begin
                        dat    = 1'b0;
                        ev_dir = 1'b1;
                        ev_up  = 1'b1;
                        wb     = 1'b1;
                    end else if (op == OP_READ) begin
                        shr = 1'b1;
                        if (cur == ST_M || cur == ST_O) st = ST_O;
                        else if (cur == ST_E) st = ST_S;
                        upd_up = lp && cur != ST_S;
                    end else if (op == OP_WRITE) begin
                        st = ST_I;
                        if (lp) begin
                            ev_dir = 1'b1;
                            ev_up  = 1'b1;
                            wb     = 1'b1;
                        end
                    end else if (op == OP_EVICT) begin
                        st = ST_I;
                        if (lp) begin
                            ev_up = 1'b1;
                            wb    = 1'b1;
                        end
                    end else begin
                        // update at the lowest private level; on a clean copy clear wins
                        if (cur == ST_M || cur == ST_O) begin
                            if (rq.sender_is_lower_link) begin
                                st     = rq.arg_is_self ? ST_O : ST_S;
                                upd_up = 1'b1;
                            end
                        end else begin
                            st  = sup;
                            act = ACT_CLEAR;
                            dst = DST_SENDER;
                            dat = 1'b0;
                        end
                    end
                end
            end
            CMD_SNOOP_MISS: begin
                if (!lp) begin
                    act = ACT_CLEAR;
                end else if (op == OP_EVICT) begin
                    act = ACT_SEND;
                    dst = DST_DIR;
                end else begin
                    ev_dir = 1'b1;
                    ev_up  = 1'b1;
                    wb     = 1'b1;
                    act    = ACT_SEND;
                    dst    = DST_SOURCE;
                end
            end
            CMD_FILL: begin
                // valid tagged victim is evicted (lowest private) or, if modified, written back
                if (rq.old_tag_valid && cur != ST_I) begin
                    if (lp) begin
                        ev_dir = 1'b1;
                        ev_up  = 1'b1;
                        wb     = 1'b1;
                        tag    = rq.old_tag;
                    end else if (cur == ST_M) begin
                        wb  = 1'b1;
                        tag = rq.old_tag;
                    end
                end
                st = ST_I;
            end
            CMD_COMPLETE: begin
                if (lp) begin
                    if (cur == ST_I) begin
                        if (rq.message_shared) begin
                            if (op == OP_READ) st = ST_S;
                            else perr = 1'b1;
                        end else if (op == OP_READ) begin
                            st = ST_E;
                        end else if (op == OP_WRITE) begin
                            st = ST_M;
                        end else if (op == OP_EVICT) begin
                            st = ST_I;
                        end else begin
                            perr = 1'b1;
                        end
                    end else if (cur == ST_M) begin
                        perr = 1'b1;
                    end else if (op == OP_WRITE) begin
                        st = ST_M;
                    end else begin
                        perr = 1'b1;
                    end
                end else if (rq.message_is_evict) begin
                    st = ST_I;
                end else if (pc) begin
                    st = sup;
                end else begin
                    st = ST_E;
                end
            end
            CMD_INVALIDATE: st = ST_I;
            default: ;
        endcase

        // reply flags and destination only survive on the actions that use them
        if (act != ACT_REPLY) begin
            shr = 1'b0;
            dat = 1'b0;
        end
        if (act != ACT_REPLY && act != ACT_SEND) dst = DST_SENDER;

        res.new_state          = st;
        res.action             = act;
        res.dest               = dst;
        res.evict_to_directory = ev_dir;
        res.evict_to_upper     = ev_up;
        res.writeback_lower    = wb;
        res.update_to_upper    = upd_up;
        res.shared_flag        = shr;
        res.response_data      = dat;
        res.message_tag        = tag;
        res.protocol_error     = perr;
        res.line_valid         = (st != ST_I);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [TAG_W-1:0] want,
                               input logic [TAG_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 30)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // one pass per clock edge: registers, then results, then new requests
    always @(posedge i_clk) begin : watch
        t_req  rq;
        t_resp got;
        t_resp want;
        int    idx;

        if (!i_rst_n) begin
            for (int i = 0; i < LINES; i++) shadow_state[i] = ST_I;
            lowest_private = 1'b0;
            private_cache  = 1'b0;
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == {CFG_LOWEST_PRIVATE, 2'b00}) lowest_private = i_pwdata[0];
                else if (i_paddr == {CFG_PRIVATE_CACHE, 2'b00}) private_cache = i_pwdata[0];
            end

            if (i_rsp_tvalid && i_rsp_tready) begin
                got = t_resp'(i_rsp_tdata);
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 30)
                        $display("%0t: unexpected result, expected none, actual %0h",
                                 $time, i_rsp_tdata);
                end else begin
                    want = expected_results.pop_front();
                    results_seen++;
                    check_field("new_state", TAG_W'(want.new_state), TAG_W'(got.new_state));
                    check_field("action", TAG_W'(want.action), TAG_W'(got.action));
                    check_field("dest", TAG_W'(want.dest), TAG_W'(got.dest));
                    check_field("evict_to_directory", TAG_W'(want.evict_to_directory),
                                TAG_W'(got.evict_to_directory));
                    check_field("evict_to_upper", TAG_W'(want.evict_to_upper),
                                TAG_W'(got.evict_to_upper));
                    check_field("writeback_lower", TAG_W'(want.writeback_lower),
                                TAG_W'(got.writeback_lower));
                    check_field("update_to_upper", TAG_W'(want.update_to_upper),
                                TAG_W'(got.update_to_upper));
                    check_field("shared_flag", TAG_W'(want.shared_flag),
                                TAG_W'(got.shared_flag));
                    check_field("response_data", TAG_W'(want.response_data),
                                TAG_W'(got.response_data));
                    check_field("message_tag", want.message_tag, got.message_tag);
                    check_field("protocol_error", TAG_W'(want.protocol_error),
                                TAG_W'(got.protocol_error));
                    check_field("line_valid", TAG_W'(want.line_valid),
                                TAG_W'(got.line_valid));
                end
            end

            if (i_req_tvalid && i_req_tready) begin
                rq   = t_req'({i_req_tuser, i_req_tdata[61:0]});
                idx  = int'(rq.line_index) % LINES;
                want = next_line_outcome(rq, shadow_state[idx], lowest_private, private_cache);
                shadow_state[idx] = want.new_state;
                expected_results.push_back(want);
                if (want.protocol_error) error_results++;
            end
        end

        o_fail_count    <= fail_count;
        o_pending       <= expected_results.size();
        o_results       <= results_seen;
        o_error_results <= error_results;
    end

endmodule

/* dv/tb_moesi_line_state_controller_core.sv */
// testbench top for moesi_line_state_controller_core: clock, reset, request and register stimulus
// depends on mlsc_pkg, moesi_line_state_controller_core and mlsc_coherence_checker
`timescale 1ns / 1ps

module tb_moesi_line_state_controller_core;
    import mlsc_pkg::*;

    localparam int LINES        = 1024;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 120;
    localparam int LONG_HOLD    = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // fields from bit 0: line_index, op_type, supplied_state, sender_is_lower_link,
    // arg_is_self, message_shared, message_is_evict, origin_is_directory, old_tag,
    // old_tag_valid, has_line, zero fill
    logic [63:0] s_axis_tdata;
    // fields: cmd
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // fields from bit 0: new_state, action, dest, evict_to_directory, evict_to_upper,
    // writeback_lower, update_to_upper, shared_flag, response_data, message_tag,
    // protocol_error, line_valid
    logic [55:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int results;
    int error_results;
    int sent_count    = 0;
    int mode_count    = 0;
    int cycles        = 0;
    bit quiet         = 1'b0;
    bit long_hold_req = 1'b0;

    moesi_line_state_controller_core #(
        .LINES (LINES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    mlsc_coherence_checker #(
        .LINES (LINES)
    ) checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_tvalid    (s_axis_tvalid),
        .i_req_tready    (s_axis_tready),
        .i_req_tdata     (s_axis_tdata),
        .i_req_tuser     (s_axis_tuser),
        .i_rsp_tvalid    (m_axis_tvalid),
        .i_rsp_tready    (m_axis_tready),
        .i_rsp_tdata     (m_axis_tdata),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_results       (results),
        .o_error_results (error_results)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("moesi_line_state_controller_core test failed");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off on request, none at the end
    initial begin
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    function automatic t_req mk_req(input t_cmd c, input logic [9:0] idx, input t_op op,
                                    input logic [2:0] sup);
        t_req rq;
        rq                = '0;
        rq.cmd            = c;
        rq.line_index     = idx;
        rq.op_type        = op;
        rq.supplied_state = sup;
        return rq;
    endfunction

    // weighted toward completions and snoops so lines move through all states
    function automatic t_req random_request();
        t_req rq;
        int   pick;
        rq   = '0;
        pick = $urandom_range(0, 99);
        if (pick < 15)      rq.cmd = CMD_LOCAL_HIT;
        else if (pick < 25) rq.cmd = CMD_LOCAL_MISS;
        else if (pick < 45) rq.cmd = CMD_SNOOP_HIT;
        else if (pick < 50) rq.cmd = CMD_SNOOP_MISS;
        else if (pick < 60) rq.cmd = CMD_FILL;
        else if (pick < 85) rq.cmd = CMD_COMPLETE;
        else if (pick < 90) rq.cmd = CMD_INVALIDATE;
        else                rq.cmd = CMD_QUERY;
        // a few hot lines at both ends of the memory, the rest anywhere
        if ($urandom_range(0, 4) != 0)
            rq.line_index = {($urandom_range(0, 1) != 0) ? 7'h7f : 7'h00,
                             3'($urandom_range(0, 7))};
        else
            rq.line_index = 10'($urandom);
        rq.op_type = 2'($urandom);
        if ($urandom_range(0, 6) != 0) rq.supplied_state = 3'($urandom_range(0, 4));
        else rq.supplied_state = 3'($urandom_range(5, 7));
        rq.sender_is_lower_link = 1'($urandom);
        rq.arg_is_self          = 1'($urandom);
        rq.message_shared       = 1'($urandom);
        rq.message_is_evict     = 1'($urandom);
        rq.origin_is_directory  = 1'($urandom);
        case ($urandom_range(0, 9))
            0:       rq.old_tag = '0;
            1:       rq.old_tag = '1;
            default: rq.old_tag = {8'($urandom), 32'($urandom)};
        endcase
        rq.old_tag_valid = 1'($urandom);
        rq.has_line      = 1'($urandom);
        return rq;
    endfunction

    // offer one request until taken, then maybe go idle for a burst
    task automatic put_req(input t_req rq);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, rq.has_line, rq.old_tag_valid, rq.old_tag,
                          rq.origin_is_directory, rq.message_is_evict, rq.message_shared,
                          rq.arg_is_self, rq.sender_is_lower_link, rq.supplied_state,
                          rq.op_type, rq.line_index};
        s_axis_tuser  <= rq.cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
        if (!quiet && (sent_count % 50) < 30 && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain everything in flight, then change the mode registers
    task automatic set_mode(input logic lp, input logic pc);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
        reg_write({CFG_LOWEST_PRIVATE, 2'b00}, {31'd0, lp});
        reg_write({CFG_PRIVATE_CACHE, 2'b00}, {31'd0, pc});
        mode_count++;
    endtask

    // stimulus and verdict
    initial begin
        t_req rq;
        int   directed_count;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk through the protocol at the lowest private level
        set_mode(1'b1, 1'b1);
        put_req(mk_req(CMD_QUERY, 10'd0, OP_READ, ST_I));
        put_req(mk_req(CMD_COMPLETE, 10'd0, OP_READ, ST_I));
        // snoop update on an exclusive copy: clear instead of reply
        put_req(mk_req(CMD_SNOOP_HIT, 10'd0, OP_UPDATE, ST_S));
        put_req(mk_req(CMD_LOCAL_HIT, 10'd0, OP_READ, ST_I));
        put_req(mk_req(CMD_COMPLETE, 10'd0, OP_WRITE, ST_I));
        put_req(mk_req(CMD_LOCAL_HIT, 10'd0, OP_UPDATE, ST_I));
        put_req(mk_req(CMD_SNOOP_HIT, 10'd0, OP_READ, ST_I));
        rq = mk_req(CMD_SNOOP_HIT, 10'd0, OP_UPDATE, ST_E);
        rq.sender_is_lower_link = 1'b1;
        rq.arg_is_self          = 1'b1;
        put_req(rq);
        // snoop write is illegal but still invalidates with a full evict
        put_req(mk_req(CMD_SNOOP_HIT, 10'd0, OP_WRITE, ST_I));
        // completions that cannot happen on an invalid line
        rq = mk_req(CMD_COMPLETE, 10'd0, OP_WRITE, ST_I);
        rq.message_shared = 1'b1;
        put_req(rq);
        put_req(mk_req(CMD_COMPLETE, 10'd0, OP_UPDATE, ST_I));
        put_req(mk_req(CMD_COMPLETE, 10'd1023, OP_WRITE, ST_I));
        put_req(mk_req(CMD_COMPLETE, 10'd1023, OP_READ, ST_I));
        put_req(mk_req(CMD_SNOOP_HIT, 10'd1023, OP_EVICT, ST_I));
        rq = mk_req(CMD_COMPLETE, 10'd1023, OP_READ, ST_I);
        rq.message_shared = 1'b1;
        put_req(rq);
        // victim eviction carrying an all-ones tag
        rq = mk_req(CMD_FILL, 10'd1023, OP_READ, ST_I);
        rq.old_tag             = '1;
        rq.old_tag_valid       = 1'b1;
        rq.origin_is_directory = 1'b1;
        put_req(rq);
        // local miss without an allocated line keeps the state
        put_req(mk_req(CMD_COMPLETE, 10'd5, OP_READ, ST_I));
        put_req(mk_req(CMD_LOCAL_MISS, 10'd5, OP_WRITE, ST_I));
        rq = mk_req(CMD_LOCAL_MISS, 10'd5, OP_UPDATE, ST_I);
        rq.has_line = 1'b1;
        put_req(rq);
        put_req(mk_req(CMD_SNOOP_MISS, 10'd9, OP_EVICT, ST_I));
        put_req(mk_req(CMD_SNOOP_MISS, 10'd9, OP_READ, ST_I));
        put_req(mk_req(CMD_LOCAL_HIT, 10'd9, OP_EVICT, ST_I));
        put_req(mk_req(CMD_COMPLETE, 10'd9, OP_READ, ST_I));
        // supplied state out of range lands as invalid
        put_req(mk_req(CMD_SNOOP_HIT, 10'd9, OP_UPDATE, 3'd7));
        put_req(mk_req(CMD_INVALIDATE, 10'd1023, OP_EVICT, 3'd7));
        put_req(mk_req(CMD_LOCAL_HIT, 10'd9, OP_WRITE, ST_I));
        directed_count = sent_count;

        // random phases over the mode settings
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_mode(1'b0, 1'b0);
                1: set_mode(1'b1, 1'b0);
                2: set_mode(1'b0, 1'b1);
                3: set_mode(1'b1, 1'b1);
                default: set_mode(1'b0, 1'b0);
            endcase
            if (phase == 2) long_hold_req = 1'b1;
            if (phase == 4) quiet = 1'b1;
            repeat (PHASE_ITEMS) put_req(random_request());
        end

        // wait out the last results and the pipeline
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);

        $display("covered %0d requests (%0d directed) over %0d mode settings",
                 sent_count, directed_count, mode_count);
        $display("compared %0d results, %0d of them flagging a protocol error",
                 results, error_results);
        if (fail_count == 0) begin
            $display("moesi_line_state_controller_core test passed");
        end else begin
            $display("moesi_line_state_controller_core test failed");
        end
        $finish;
    end

endmodule

/* moesi_line_state_controller_core.f */
hdl/mlsc_pkg.sv
hdl/mlsc_next_state.sv
hdl/moesi_line_state_controller_core.sv
dv/mlsc_coherence_checker.sv
dv/tb_moesi_line_state_controller_core.sv
